// ===== src/esc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enrollment sequence checker package
// Event, transition and error codes, and the transaction layouts of both
// stream channels.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;
   localparam int CFG_DATA_W  = 8;

   // event codes
   localparam logic [4:0] EV_NONE    = 5'd0;
   localparam logic [4:0] EV_IRQ2    = 5'd1;
   localparam logic [4:0] EV_CMD22   = 5'd2;
   localparam logic [4:0] EV_ACK22   = 5'd3;
   localparam logic [4:0] EV_PRIMARY = 5'd4;
   localparam logic [4:0] EV_CMD34   = 5'd5;
   localparam logic [4:0] EV_ACK34   = 5'd6;
   localparam logic [4:0] EV_IRQ0200 = 5'd7;
   localparam logic [4:0] EV_CMD20   = 5'd8;
   localparam logic [4:0] EV_ACK20   = 5'd9;
   localparam logic [4:0] EV_AUX     = 5'd10;
   localparam logic [4:0] EV_CMD32   = 5'd11;
   localparam logic [4:0] EV_ACK32   = 5'd12;
   localparam logic [4:0] EV_CMD50   = 5'd13;
   localparam logic [4:0] EV_ACK50   = 5'd14;
   localparam logic [4:0] EV_NAV     = 5'd15;
   localparam logic [4:0] EV_CMD36   = 5'd16;
   localparam logic [4:0] EV_ACK36   = 5'd17;
   localparam logic [4:0] EV_IRQ0100 = 5'd18;

   // transition kinds
   localparam logic [1:0] TK_NONE     = 2'd0;
   localparam logic [1:0] TK_FIRST    = 2'd1;
   localparam logic [1:0] TK_REARM    = 2'd2;
   localparam logic [1:0] TK_TERMINAL = 2'd3;

   // error codes
   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_TERMINAL   = 2'd1;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd2;
   localparam logic [1:0] ERR_REJECTED   = 2'd3;

   // register indexes
   localparam logic CSR_REQUIRED_STAGES = 1'b0;
   localparam logic CSR_DEFER_TERMINAL  = 1'b1;

   typedef struct packed {
      logic [1:0] pad;
      logic       stage_reject;
      logic [4:0] event_code;
   } req_data_type;

   typedef struct packed {
      logic [3:0] pad;
      logic       failed;
      logic       done_res;
      logic [7:0] completed_stages;
      logic [7:0] stage_number;
      logic       stage_report;
      logic [1:0] transition_kind;
      logic [4:0] next_expected;
      logic [1:0] error_code;
   } rsp_data_type;

endpackage

// ===== src/enrollment_sequence_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enrollment sequence checker
// Follows an enrollment exchange one event code per transaction and reports
// errors, stage reports and progress.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle and returns one result per event,
// in the cycle after the event is accepted. Each event is decided by a single
// pass of next-state logic on the sequence registers, so events follow back
// to back while rsp_tready stays high. A new event enters in the cycle in which
// the previous result is taken; while a result waits on rsp_tready, req_tready
// stays low. Registers written on the csr port take effect on the next event.
module enrollment_sequence_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // event_code[4:0], stage_reject[5], zero[7:6]
   input  logic [esc_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // error_code[1:0], next_expected[6:2], transition_kind[8:7],
   // stage_report[9], stage_number[17:10], completed_stages[25:18],
   // done_res[26], failed[27], zero[31:28]
   output logic [esc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [esc_pkg::CFG_DATA_W-1:0]  csr_wdata
);
   import esc_pkg::*;

   logic [7:0]   required_ff;
   logic         defer_ff;
   logic [4:0]   expected_ff, expected_in;
   logic [1:0]   transition_ff, transition_in;
   logic [7:0]   observed_ff, observed_in;
   logic [7:0]   accepted_ff, accepted_in;
   logic         complete_ff, complete_in;
   logic         fail_ff, fail_in;
   logic         after_aux_ff, after_aux_in;
   logic         nav_seen_ff, nav_seen_in;
   logic         pending_ff, pending_in;
   logic         rsp_tvalid_ff;
   rsp_data_type rsp_data_ff, rsp_data_in;

   req_data_type req_data;
   logic         req_accept;
   logic [4:0]   ev;
   logic         reject;
   logic [1:0]   err;
   logic         rep;
   logic [7:0]   num;
   logic [7:0]   obs_inc;
   logic [1:0]   kind;

   assign req_data   = req_data_type'(req_tdata);
   assign ev         = req_data.event_code;
   assign reject     = req_data.stage_reject;
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   always_comb begin
      expected_in   = expected_ff;
      transition_in = transition_ff;
      observed_in   = observed_ff;
      accepted_in   = accepted_ff;
      complete_in   = complete_ff;
      fail_in       = fail_ff;
      after_aux_in  = after_aux_ff;
      nav_seen_in   = nav_seen_ff;
      pending_in    = pending_ff;
      err           = ERR_OK;
      rep           = 1'b0;
      num           = 8'd0;
      obs_inc       = observed_ff + 8'd1;
      kind          = TK_REARM;
      if (obs_inc == 8'd1) begin
         kind = TK_FIRST;
      end else if (obs_inc == required_ff) begin
         kind = TK_TERMINAL;
      end

      priority if (complete_ff || fail_ff) begin
         err = ERR_TERMINAL;
      end else if (ev != expected_ff || ev == EV_NONE) begin
         fail_in     = 1'b1;
         expected_in = EV_NONE;
         err         = ERR_UNEXPECTED;
      end else begin
         unique case (ev)
            EV_IRQ2: begin
               transition_in = TK_NONE;
               expected_in   = EV_CMD22;
            end
            EV_CMD22: expected_in = EV_ACK22;
            EV_ACK22: expected_in = EV_PRIMARY;
            EV_PRIMARY: begin
               if (observed_ff >= required_ff) begin
                  fail_in     = 1'b1;
                  expected_in = EV_NONE;
                  err         = ERR_UNEXPECTED;
               end else begin
                  observed_in   = obs_inc;
                  transition_in = kind;
                  if (kind == TK_TERMINAL && defer_ff) begin
                     pending_in  = 1'b1;
                     expected_in = EV_CMD34;
                  end else begin
                     rep = 1'b1;
                     num = obs_inc;
                     if (reject) begin
                        fail_in     = 1'b1;
                        expected_in = EV_NONE;
                        err         = ERR_REJECTED;
                     end else begin
                        accepted_in = accepted_ff + 8'd1;
                        expected_in = EV_CMD34;
                     end
                  end
               end
            end
            EV_CMD34: expected_in = EV_ACK34;
            EV_ACK34: begin
               if (transition_ff == TK_FIRST || after_aux_ff) begin
                  expected_in = EV_IRQ0200;
               end else begin
                  expected_in = EV_CMD36;
               end
            end
            EV_CMD36:   expected_in = EV_ACK36;
            EV_ACK36:   expected_in = EV_IRQ0100;
            EV_IRQ0100: expected_in = EV_CMD20;
            EV_CMD20:   expected_in = EV_ACK20;
            EV_ACK20:   expected_in = EV_AUX;
            EV_AUX: begin
               if (transition_ff == TK_FIRST) begin
                  expected_in = EV_CMD32;
               end else begin
                  after_aux_in = 1'b1;
                  expected_in  = EV_CMD34;
               end
            end
            EV_IRQ0200: begin
               after_aux_in = 1'b0;
               if (transition_ff == TK_FIRST) begin
                  expected_in = EV_CMD20;
               end else if (transition_ff == TK_TERMINAL) begin
                  if (pending_ff) begin
                     rep = 1'b1;
                     num = observed_ff;
                  end
                  if (pending_ff && reject) begin
                     fail_in     = 1'b1;
                     expected_in = EV_NONE;
                     err         = ERR_REJECTED;
                  end else begin
                     if (pending_ff) begin
                        accepted_in = accepted_ff + 8'd1;
                        pending_in  = 1'b0;
                     end
                     complete_in = 1'b1;
                     expected_in = EV_NONE;
                  end
               end else begin
                  expected_in = EV_CMD32;
               end
            end
            EV_CMD32: expected_in = EV_ACK32;
            EV_ACK32: begin
               if (transition_ff == TK_FIRST && !nav_seen_ff) begin
                  expected_in = EV_CMD50;
               end else begin
                  expected_in = EV_IRQ2;
               end
            end
            EV_CMD50: expected_in = EV_ACK50;
            EV_ACK50: expected_in = EV_NAV;
            EV_NAV: begin
               nav_seen_in = 1'b1;
               expected_in = EV_CMD32;
            end
            default: begin
               fail_in     = 1'b1;
               expected_in = EV_NONE;
               err         = ERR_UNEXPECTED;
            end
         endcase
      end

      rsp_data_in                  = '0;
      rsp_data_in.error_code       = err;
      rsp_data_in.next_expected    = expected_in;
      rsp_data_in.transition_kind  = transition_in;
      rsp_data_in.stage_report     = rep;
      rsp_data_in.stage_number     = num;
      rsp_data_in.completed_stages = accepted_in;
      rsp_data_in.done_res         = complete_in;
      rsp_data_in.failed           = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff <= 8'd2;
         defer_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REQUIRED_STAGES: required_ff <= csr_wdata[7:0];
            CSR_DEFER_TERMINAL:  defer_ff    <= csr_wdata[0];
            default:             required_ff <= required_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= EV_IRQ2;
         transition_ff <= TK_NONE;
         observed_ff   <= 8'd0;
         accepted_ff   <= 8'd0;
         complete_ff   <= 1'b0;
         fail_ff       <= 1'b0;
         after_aux_ff  <= 1'b0;
         nav_seen_ff   <= 1'b0;
         pending_ff    <= 1'b0;
      end else if (req_accept) begin
         expected_ff   <= expected_in;
         transition_ff <= transition_in;
         observed_ff   <= observed_in;
         accepted_ff   <= accepted_in;
         complete_ff   <= complete_in;
         fail_ff       <= fail_in;
         after_aux_ff  <= after_aux_in;
         nav_seen_ff   <= nav_seen_in;
         pending_ff    <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_tvalid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== src/esc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enrollment sequence checker assertions
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [esc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [esc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import esc_pkg::*;

   rsp_data_type rsp_data;
   req_data_type req_data;

   assign rsp_data = rsp_data_type'(rsp_tdata);
   assign req_data = req_data_type'(req_tdata);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // every accepted transaction yields a result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_data.event_code == req_data.event_code
      |=> rsp_tvalid)
      else $error("accepted transaction gave no result");

   a_end_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_data.failed || rsp_data.done_res)
      |-> rsp_data.next_expected == EV_NONE)
      else $error("finished or failed sequence still expects an event");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.error_code == ERR_REJECTED
      |-> rsp_data.stage_report && rsp_data.failed && !rsp_data.done_res)
      else $error("rejected report without failure");

   a_stage_number: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data.stage_report |-> rsp_data.stage_number == 8'd0)
      else $error("stage number without stage report");

endmodule

bind enrollment_sequence_checker esc_checker u_esc_checker (.*);

// ===== test/tb_enrollment_sequence_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enrollment sequence checker testbench
// Drives one long enrollment exchange through the stream port and checks every
// result against a cycle-free prediction of the sequence registers. The run
// opens with a scripted first stage, covers register writes between events,
// back-pressure that stalls the event port, many random well-formed stages,
// one randomly chosen way of closing the exchange, and events after the
// terminal state. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_enrollment_sequence_checker;
   import esc_pkg::*;

   localparam int unsigned IDLE_PCT    = 14;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic                   csr_index  = 1'b0;
   logic [CFG_DATA_W-1:0]  csr_wdata  = '0;

   // predicted sequence registers and configuration
   logic [7:0] stage_target;
   logic       defer_last;
   logic [4:0] want_event;
   logic [1:0] phase_kind;
   logic [7:0] captures_seen;
   logic [7:0] reports_taken;
   logic       seq_done;
   logic       seq_failed;
   logic       aux_done;
   logic       nav_done;
   logic       held_report;

   rsp_data_type pending_verdicts[$];

   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned events_sent   = 0;
   int unsigned reports_seen  = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   logic        steady_flow   = 1'b0;
   string       closing_case  = "none";

   enrollment_sequence_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_verdicts.size());
         $display("** enrollment_sequence_checker: FAILED **");
         $finish;
      end
   end

   // result side: random stalls, long hold-offs on request
   always @(posedge clock) begin
      if (hold_left == 0 && hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   function automatic void reset_enrollment();
      stage_target  = 8'd2;
      defer_last    = 1'b0;
      want_event    = EV_IRQ2;
      phase_kind    = TK_NONE;
      captures_seen = '0;
      reports_taken = '0;
      seq_done      = 1'b0;
      seq_failed    = 1'b0;
      aux_done      = 1'b0;
      nav_done      = 1'b0;
      held_report   = 1'b0;
   endfunction

   function automatic void abort_enrollment();
      seq_failed = 1'b1;
      want_event = EV_NONE;
   endfunction

   // issue a stage report; false when the host refuses it
   function automatic logic issue_report(input logic reject, inout rsp_data_type r);
      r.stage_report = 1'b1;
      r.stage_number = captures_seen;
      if (reject) begin
         abort_enrollment();
         r.error_code = ERR_REJECTED;
         return 1'b0;
      end
      reports_taken = reports_taken + 8'd1;
      return 1'b1;
   endfunction

   function automatic rsp_data_type advance_enrollment(input logic [4:0] code,
                                                       input logic reject);
      rsp_data_type r;
      r = '0;
      r.error_code = ERR_OK;
      if (seq_done || seq_failed) begin
         r.error_code = ERR_TERMINAL;
      end else if (code != want_event || code == EV_NONE) begin
         abort_enrollment();
         r.error_code = ERR_UNEXPECTED;
      end else begin
         case (code)
            EV_IRQ2: begin
               phase_kind = TK_NONE;
               want_event = EV_CMD22;
            end
            EV_CMD22: want_event = EV_ACK22;
            EV_ACK22: want_event = EV_PRIMARY;
            EV_PRIMARY: begin
               if (captures_seen >= stage_target) begin
                  abort_enrollment();
                  r.error_code = ERR_UNEXPECTED;
               end else begin
                  captures_seen = captures_seen + 8'd1;
                  if (captures_seen == 8'd1)
                     phase_kind = TK_FIRST;
                  else if (captures_seen == stage_target)
                     phase_kind = TK_TERMINAL;
                  else
                     phase_kind = TK_REARM;
                  if (phase_kind == TK_TERMINAL && defer_last) begin
                     held_report = 1'b1;
                     want_event  = EV_CMD34;
                  end else if (issue_report(reject, r)) begin
                     want_event = EV_CMD34;
                  end
               end
            end
            EV_CMD34: want_event = EV_ACK34;
            EV_ACK34: want_event = (phase_kind == TK_FIRST || aux_done) ? EV_IRQ0200 : EV_CMD36;
            EV_CMD36: want_event = EV_ACK36;
            EV_ACK36: want_event = EV_IRQ0100;
            EV_IRQ0100: want_event = EV_CMD20;
            EV_CMD20: want_event = EV_ACK20;
            EV_ACK20: want_event = EV_AUX;
            EV_AUX: begin
               if (phase_kind == TK_FIRST) begin
                  want_event = EV_CMD32;
               end else begin
                  aux_done   = 1'b1;
                  want_event = EV_CMD34;
               end
            end
            EV_IRQ0200: begin
               aux_done = 1'b0;
               if (phase_kind == TK_FIRST) begin
                  want_event = EV_CMD20;
               end else if (phase_kind == TK_TERMINAL) begin
                  if (!held_report || issue_report(reject, r)) begin
                     held_report = 1'b0;
                     seq_done    = 1'b1;
                     want_event  = EV_NONE;
                  end
               end else begin
                  want_event = EV_CMD32;
               end
            end
            EV_CMD32: want_event = EV_ACK32;
            EV_ACK32: want_event = (phase_kind == TK_FIRST && !nav_done) ? EV_CMD50 : EV_IRQ2;
            EV_CMD50: want_event = EV_ACK50;
            EV_ACK50: want_event = EV_NAV;
            EV_NAV: begin
               nav_done   = 1'b1;
               want_event = EV_CMD32;
            end
            default: begin
               abort_enrollment();
               r.error_code = ERR_UNEXPECTED;
            end
         endcase
      end
      r.next_expected    = want_event;
      r.transition_kind  = phase_kind;
      r.completed_stages = reports_taken;
      r.done_res         = seq_done;
      r.failed           = seq_failed;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_data_type seen;
      rsp_data_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (pending_verdicts.size() == 0) begin
            $error("result %h with no event outstanding", rsp_tdata);
            mismatches++;
         end else begin
            due = pending_verdicts.pop_front();
            if (due.stage_report)
               reports_seen++;
            compare_field("error_code",       due.error_code,       seen.error_code);
            compare_field("next_expected",    due.next_expected,    seen.next_expected);
            compare_field("transition_kind",  due.transition_kind,  seen.transition_kind);
            compare_field("stage_report",     due.stage_report,     seen.stage_report);
            compare_field("stage_number",     due.stage_number,     seen.stage_number);
            compare_field("completed_stages", due.completed_stages, seen.completed_stages);
            compare_field("done_res",         due.done_res,         seen.done_res);
            compare_field("failed",           due.failed,           seen.failed);
         end
      end
   end

   task automatic send_event(input logic [4:0] code, input logic reject);
      req_data_type item;
      item = '0;
      item.event_code   = code;
      item.stage_reject = reject;
      if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tdata  <= item;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_verdicts.push_back(advance_enrollment(code, reject));
      events_sent++;
   endtask

   // refuse only where a report would be issued, random elsewhere
   function automatic logic reject_bit(input logic refuse_report);
      if (want_event == EV_PRIMARY || (want_event == EV_IRQ0200 && held_report))
         return refuse_report;
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_expected(input logic refuse_report);
      send_event(want_event, reject_bit(refuse_report));
   endtask

   // drop valid and wait until every result is back
   task automatic settle_stream();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   task automatic write_register(input logic idx, input logic [7:0] value);
      settle_stream();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_REQUIRED_STAGES)
         stage_target = value;
      else
         defer_last = value[0];
   endtask

   task automatic run_to_close(input logic refuse_report);
      while (!seq_done && !seq_failed)
         send_expected(refuse_report);
   endtask

   task automatic test_first_stage();
      repeat (17) send_expected(1'b0);
   endtask

   task automatic test_register_extremes();
      write_register(CSR_REQUIRED_STAGES, 8'd0);
      write_register(CSR_REQUIRED_STAGES, 8'd1);
      write_register(CSR_DEFER_TERMINAL, 8'd1);
      write_register(CSR_DEFER_TERMINAL, 8'd0);
      write_register(CSR_REQUIRED_STAGES, 8'd255);
   endtask

   task automatic test_backpressure();
      hold_requests++;
      repeat (24) send_expected(1'b0);
      settle_stream();
   endtask

   task automatic test_random_stages();
      int unsigned n;
      for (n = 0; n < 960; n++) begin
         steady_flow = (n >= 300 && n < 520);
         if ($urandom_range(0, 39) == 0) begin
            if ($urandom_range(0, 2) == 0)
               write_register(CSR_DEFER_TERMINAL, 8'($urandom_range(0, 1)));
            else
               write_register(CSR_REQUIRED_STAGES,
                              8'($urandom_range(int'(captures_seen) + 80, 255)));
         end
         send_expected(1'b0);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_sequence_end();
      int unsigned choice;
      logic [4:0]  bad;
      choice = $urandom_range(0, 5);
      case (choice)
         0, 1: begin
            closing_case = (choice == 1) ? "completion with deferred report" : "completion";
            write_register(CSR_DEFER_TERMINAL, 8'(choice));
            write_register(CSR_REQUIRED_STAGES, captures_seen + 8'd1);
            run_to_close(1'b0);
         end
         2: begin
            closing_case = "refused stage report";
            run_to_close(1'b1);
         end
         3: begin
            closing_case = "refused deferred report";
            write_register(CSR_DEFER_TERMINAL, 8'd1);
            write_register(CSR_REQUIRED_STAGES, captures_seen + 8'd1);
            run_to_close(1'b1);
         end
         4: begin
            closing_case = "unexpected event";
            repeat ($urandom_range(0, 16)) send_expected(1'b0);
            do bad = 5'($urandom_range(0, 31)); while (bad == want_event);
            send_event(bad, 1'($urandom_range(0, 1)));
         end
         default: begin
            closing_case = "capture beyond the stage target";
            case ($urandom_range(0, 2))
               0: write_register(CSR_REQUIRED_STAGES, 8'd0);
               1: write_register(CSR_REQUIRED_STAGES, 8'd1);
               default: write_register(CSR_REQUIRED_STAGES, captures_seen);
            endcase
            run_to_close(1'b0);
         end
      endcase
   endtask

   task automatic test_terminal_events();
      repeat (40) send_event(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      reset_enrollment();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_stage();
      test_register_extremes();
      test_backpressure();
      test_random_stages();
      test_sequence_end();
      test_terminal_events();

      settle_stream();
      repeat (8) @(posedge clock);
      $display("%0d events over %0d capture stages, %0d stage reports, closed by %s",
               events_sent, captures_seen, reports_seen, closing_case);
      $display("mismatches: %0d, cycles: %0d", mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("** enrollment_sequence_checker: PASSED **");
      end else begin
         $display("** enrollment_sequence_checker: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/esc_pkg.sv
src/enrollment_sequence_checker.sv
src/esc_checker.sv
test/tb_enrollment_sequence_checker.sv
